// ===== rtl/tonewheel_organ_voice_engine_core_macros.svh =====
// Assertion macros for the tonewheel organ voice engine.
// Included by the top level; no other dependencies.
`ifndef TONEWHEEL_ORGAN_VOICE_ENGINE_CORE_MACROS_SVH
`define TONEWHEEL_ORGAN_VOICE_ENGINE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TOV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tov assertion failed");
`define TOV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tov assertion failed");
`else
`define TOV_ASSERT(lbl, clk, rst_n, prop)
`define TOV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tov_pkg.sv =====
// Shared types, constants and tables of the tonewheel organ voice engine.
// No dependencies.
package tov_pkg;

    localparam int WHEEL_COUNT = 92;
    localparam int WHL_W       = 7;
    localparam int KEY_W       = 6;
    localparam int BAR_W       = 4;
    localparam logic [WHL_W-1:0] WHEEL_LAST   = 7'd91;
    localparam logic [WHL_W-1:0] SQUARE_LIMIT = 7'd13;
    localparam logic [3:0]       POS_MAX      = 4'd8;
    localparam logic [7:0]       VOL_CLIP     = 8'd127;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_KEY_DOWN = 2'd1,
        CMD_KEY_UP   = 2'd2,
        CMD_DRAWBAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic             accept;
        logic             clr_wr;
        logic             vclr_wr;
        logic             rb_rd;
        logic             rb_wr;
        logic             tk_rd;
        logic             tk_wr;
        logic             tk_acc;
        logic             acc_clr;
        logic             out_load;
        logic [WHL_W-1:0] wheel;
        logic [KEY_W-1:0] key;
        logic [BAR_W-1:0] bar;
    } t_ctl;

    typedef struct packed {
        logic is_tick;
        logic rebuild;
        logic held;
        logic out_free;
    } t_sts;

    localparam logic [6:0] LEVEL_ROM [9] = '{
        7'd0, 7'd11, 7'd16, 7'd23, 7'd32, 7'd45, 7'd64, 7'd90, 7'd127
    };

    localparam logic [5:0] HARMONIC_ROM [9] = '{
        6'd0, 6'd19, 6'd12, 6'd24, 6'd31, 6'd36, 6'd40, 6'd43, 6'd48
    };

    localparam logic [15:0] RATE_ROM [WHEEL_COUNT] = '{
        16'd0, 16'd178, 16'd188, 16'd200, 16'd212, 16'd224, 16'd237, 16'd252,
        16'd267, 16'd282, 16'd299, 16'd317, 16'd336, 16'd356, 16'd377, 16'd400,
        16'd424, 16'd449, 16'd475, 16'd504, 16'd534, 16'd565, 16'd599, 16'd635,
        16'd672, 16'd712, 16'd755, 16'd800, 16'd848, 16'd898, 16'd951, 16'd1008,
        16'd1068, 16'd1131, 16'd1199, 16'd1270, 16'd1345, 16'd1425, 16'd1510,
        16'd1601, 16'd1696, 16'd1796, 16'd1903, 16'd2017, 16'd2137, 16'd2263,
        16'd2398, 16'd2541, 16'd2691, 16'd2851, 16'd3021, 16'd3202, 16'd3392,
        16'd3593, 16'd3806, 16'd4034, 16'd4274, 16'd4526, 16'd4797, 16'd5082,
        16'd5383, 16'd5703, 16'd6042, 16'd6404, 16'd6784, 16'd7187, 16'd7612,
        16'd8068, 16'd8548, 16'd9052, 16'd9595, 16'd10164, 16'd10766, 16'd11406,
        16'd12084, 16'd12809, 16'd13568, 16'd14375, 16'd15225, 16'd16137,
        16'd17096, 16'd18105, 16'd19190, 16'd20328, 16'd21533, 16'd22838,
        16'd24205, 16'd25645, 16'd27158, 16'd28785, 16'd30492, 16'd32299
    };

    // first half period; second half is the negation
    localparam logic [7:0] SINE_HALF [128] = '{
        8'h00, 8'h03, 8'h06, 8'h09, 8'h0c, 8'h10, 8'h13, 8'h16, 8'h19, 8'h1c,
        8'h1f, 8'h22, 8'h25, 8'h28, 8'h2b, 8'h2e, 8'h31, 8'h33, 8'h36, 8'h39,
        8'h3c, 8'h3f, 8'h41, 8'h44, 8'h47, 8'h49, 8'h4c, 8'h4e, 8'h51, 8'h53,
        8'h55, 8'h58, 8'h5a, 8'h5c, 8'h5e, 8'h60, 8'h62, 8'h64, 8'h66, 8'h68,
        8'h6a, 8'h6b, 8'h6d, 8'h6f, 8'h70, 8'h71, 8'h73, 8'h74, 8'h75, 8'h76,
        8'h78, 8'h79, 8'h7a, 8'h7a, 8'h7b, 8'h7c, 8'h7d, 8'h7d, 8'h7e, 8'h7e,
        8'h7e, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7e, 8'h7e,
        8'h7e, 8'h7d, 8'h7d, 8'h7c, 8'h7b, 8'h7a, 8'h7a, 8'h79, 8'h78, 8'h76,
        8'h75, 8'h74, 8'h73, 8'h71, 8'h70, 8'h6f, 8'h6d, 8'h6b, 8'h6a, 8'h68,
        8'h66, 8'h64, 8'h62, 8'h60, 8'h5e, 8'h5c, 8'h5a, 8'h58, 8'h55, 8'h53,
        8'h51, 8'h4e, 8'h4c, 8'h49, 8'h47, 8'h44, 8'h41, 8'h3f, 8'h3c, 8'h39,
        8'h36, 8'h33, 8'h31, 8'h2e, 8'h2b, 8'h28, 8'h25, 8'h22, 8'h1f, 8'h1c,
        8'h19, 8'h16, 8'h13, 8'h10, 8'h0c, 8'h09, 8'h06, 8'h03
    };

    function automatic logic signed [7:0] sine(input logic [7:0] idx);
        logic [7:0] q;
        q = SINE_HALF[idx[6:0]];
        return idx[7] ? $signed(-q) : $signed(q);
    endfunction

    // fold a key+harmonic wheel number back into the wheel range
    function automatic logic [WHL_W-1:0] fold_wheel(input logic [WHL_W-1:0] w);
        logic [WHL_W-1:0] r;
        if (w < 7'd13) begin
            r = w + 7'd12;
        end else if (w > 7'd103) begin
            r = w - 7'd24;
        end else if (w > 7'd91) begin
            r = w - 7'd12;
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

// ===== rtl/tonewheel_organ_voice_engine_core.sv =====
// Tonewheel organ voice engine, top level: controller plus datapath.
// Depends on tov_pkg, tov_ctrl, tov_dp and the assertion macro header.
//
// Usage:
//  - Input channel (i_valid / o_stall): one word per command: sample tick,
//    key down, key up or drawbar set. A word is taken when i_valid is high
//    and o_stall is low. Only one word is worked on at a time.
//  - Output channel (o_valid / i_stall): one o_sample word per tick.
//  - Tick: a read, a phase update and a mix step per wheel over 91 wheels,
//    then the output register; the steps are serialised by the single-port
//    phase and volume memories.
//  - Key or drawbar change: a volume clear pass over all 92 wheels, then a
//    pass over the keys with a read and a write step per drawbar of each
//    held key (read-add-write on the volume memory). Ignored or no-op
//    commands are taken without further work.
//  - Reset: a clearing pass over all 92 wheels zeroes the phase and volume memories;
//    o_stall is high until it ends.
//  - Output stall: the finished sample waits in the output register; the
//    next word can be taken meanwhile, and a later tick waits at its end
//    until the register is free.
`include "tonewheel_organ_voice_engine_core_macros.svh"
module tonewheel_organ_voice_engine_core #(
    parameter int KEY_COUNT = 62,
    parameter int BAR_COUNT = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [5:0]         i_key,
    input  logic [3:0]         i_drawbar_number,
    input  logic [3:0]         i_position,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample
);
    tov_pkg::t_ctl s_ctl;
    tov_pkg::t_sts s_sts;
    logic          w_ready;

    tov_ctrl #(
        .KEY_COUNT (KEY_COUNT),
        .BAR_COUNT (BAR_COUNT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (s_sts),
        .o_ctl   (s_ctl),
        .o_ready (w_ready)
    );

    tov_dp #(
        .KEY_COUNT (KEY_COUNT),
        .BAR_COUNT (BAR_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (s_ctl),
        .o_sts            (s_sts),
        .i_cmd            (i_cmd),
        .i_key            (i_key),
        .i_drawbar_number (i_drawbar_number),
        .i_position       (i_position),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_sample         (o_sample)
    );

    // busy whenever the sequencer is not waiting for a word
    assign o_stall = !w_ready;

    // a sample is only loaded into a free output register
    `TOV_ASSERT(a_load_free, i_clk, i_rst_n, !s_ctl.out_load || !o_valid || !i_stall)
    // a tick keeps the input stalled on the next cycle
    `TOV_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, s_ctl.accept && s_sts.is_tick, o_stall)
    // memory writes never overlap
    `TOV_ASSERT(a_one_wr, i_clk, i_rst_n, $onehot0({s_ctl.clr_wr, s_ctl.vclr_wr, s_ctl.rb_wr, s_ctl.tk_wr}))

endmodule

// ===== rtl/tov_ctrl.sv =====
// Sequencer of the voice engine: clear pass, volume rebuild, tick scan.
// Depends on tov_pkg.
module tov_ctrl #(
    parameter int KEY_COUNT = 62,
    parameter int BAR_COUNT = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tov_pkg::t_sts i_sts,
    output tov_pkg::t_ctl o_ctl,
    output logic          o_ready
);
    localparam int BW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_VCLR, S_KEY, S_RD, S_WR, S_TRD, S_TWR, S_TACC, S_OUT
    } t_state;

    t_state                    r_state, n_state;
    logic [tov_pkg::WHL_W-1:0] r_w, n_w;
    logic [tov_pkg::KEY_W-1:0] r_k, n_k;
    logic [BW-1:0]             r_d, n_d;

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        n_k     = r_k;
        n_d     = r_d;
        o_ctl       = '0;
        o_ctl.wheel = r_w;
        o_ctl.key   = r_k;
        o_ctl.bar   = tov_pkg::BAR_W'(r_d);
        case (r_state)
            S_CLR: begin
                o_ctl.clr_wr = 1'b1;
                if (r_w == tov_pkg::WHEEL_LAST) begin
                    n_w     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.accept = 1'b1;
                    if (i_sts.is_tick) begin
                        o_ctl.acc_clr = 1'b1;
                        n_w     = 7'd1;
                        n_state = S_TRD;
                    end else if (i_sts.rebuild) begin
                        n_w     = '0;
                        n_state = S_VCLR;
                    end
                end
            end
            S_VCLR: begin
                o_ctl.vclr_wr = 1'b1;
                if (r_w == tov_pkg::WHEEL_LAST) begin
                    n_k     = 6'd1;
                    n_state = S_KEY;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            S_KEY: begin
                if (r_k == tov_pkg::KEY_W'(KEY_COUNT)) begin
                    n_state = S_IDLE;
                end else if (i_sts.held) begin
                    n_d     = '0;
                    n_state = S_RD;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_RD: begin
                o_ctl.rb_rd = 1'b1;
                n_state     = S_WR;
            end
            S_WR: begin
                o_ctl.rb_wr = 1'b1;
                if (r_d == BW'(BAR_COUNT - 1)) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_KEY;
                end else begin
                    n_d     = r_d + 1'b1;
                    n_state = S_RD;
                end
            end
            S_TRD: begin
                o_ctl.tk_rd = 1'b1;
                n_state     = S_TWR;
            end
            S_TWR: begin
                o_ctl.tk_wr = 1'b1;
                n_state     = S_TACC;
            end
            S_TACC: begin
                o_ctl.tk_acc = 1'b1;
                if (r_w == tov_pkg::WHEEL_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_w     = r_w + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_w     <= '0;
            r_k     <= '0;
            r_d     <= '0;
        end else begin
            r_state <= n_state;
            r_w     <= n_w;
            r_k     <= n_k;
            r_d     <= n_d;
        end
    end

endmodule

// ===== rtl/tov_dp.sv =====
// Datapath: key map, drawbar gains, phase and volume memories, mixer, output word.
// Depends on tov_pkg.
module tov_dp #(
    parameter int KEY_COUNT = 62,
    parameter int BAR_COUNT = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tov_pkg::t_ctl      i_ctl,
    output tov_pkg::t_sts      o_sts,
    input  logic [1:0]         i_cmd,
    input  logic [5:0]         i_key,
    input  logic [3:0]         i_drawbar_number,
    input  logic [3:0]         i_position,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [15:0] o_sample
);
    localparam int KW = $clog2(KEY_COUNT);
    localparam int BW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;

    logic [KEY_COUNT-1:0] r_held;
    logic [6:0]           r_level [BAR_COUNT];

    logic       w_key_ok, w_held_cur, w_key_cmd, w_want, w_key_chg, w_bar_ok;
    logic [3:0] w_bar_idx;

    // decode of the word at the input port
    assign w_key_ok   = (i_key != '0) && ({1'b0, i_key} < 7'(KEY_COUNT));
    assign w_held_cur = w_key_ok ? r_held[i_key[KW-1:0]] : 1'b0;
    assign w_key_cmd  = (i_cmd == tov_pkg::CMD_KEY_DOWN) || (i_cmd == tov_pkg::CMD_KEY_UP);
    assign w_want     = (i_cmd == tov_pkg::CMD_KEY_DOWN);
    assign w_key_chg  = w_key_cmd && w_key_ok && (w_held_cur != w_want);
    assign w_bar_ok   = (i_cmd == tov_pkg::CMD_DRAWBAR) && (i_drawbar_number != '0)
                      && ({1'b0, i_drawbar_number} <= 5'(BAR_COUNT))
                      && (i_position <= tov_pkg::POS_MAX);
    assign w_bar_idx  = i_drawbar_number - 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            for (int i = 0; i < BAR_COUNT; i++) begin
                r_level[i] <= '0;
            end
        end else if (i_ctl.accept) begin
            if (w_key_chg) begin
                r_held[i_key[KW-1:0]] <= w_want;
            end
            if (w_bar_ok) begin
                r_level[w_bar_idx[BW-1:0]] <= tov_pkg::LEVEL_ROM[i_position];
            end
        end
    end

    // volume memory
    logic [7:0]                m_vol [tov_pkg::WHEEL_COUNT];
    logic [7:0]                r_vol_q;
    logic [tov_pkg::WHL_W-1:0] w_fold, w_vaddr;
    logic [8:0]                w_vsum;
    logic [7:0]                w_vnew;

    assign w_fold  = tov_pkg::fold_wheel({1'b0, i_ctl.key}
                                         + {1'b0, tov_pkg::HARMONIC_ROM[i_ctl.bar]});
    assign w_vaddr = (i_ctl.rb_rd || i_ctl.rb_wr) ? w_fold : i_ctl.wheel;
    assign w_vsum  = {1'b0, r_vol_q} + {2'b0, r_level[i_ctl.bar[BW-1:0]]};
    assign w_vnew  = w_vsum[8] ? tov_pkg::VOL_CLIP : w_vsum[7:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr || i_ctl.vclr_wr) begin
            m_vol[w_vaddr] <= '0;
        end else if (i_ctl.rb_wr) begin
            m_vol[w_vaddr] <= w_vnew;
        end
        if (i_ctl.rb_rd || i_ctl.tk_rd) begin
            r_vol_q <= m_vol[w_vaddr];
        end
    end

    // phase memory and mixer
    logic [15:0] m_ph [tov_pkg::WHEEL_COUNT];
    logic [15:0] r_ph_q, r_ph, w_ph_new;
    logic [3:0]  r_vsh;
    logic        r_sq;
    logic signed [7:0]  w_wave;
    logic signed [12:0] w_prod;
    logic [15:0] r_acc;

    assign w_ph_new = r_ph_q + tov_pkg::RATE_ROM[i_ctl.wheel];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr) begin
            m_ph[i_ctl.wheel] <= '0;
        end else if (i_ctl.tk_wr && (r_vol_q != '0)) begin
            m_ph[i_ctl.wheel] <= w_ph_new;
        end
        if (i_ctl.tk_rd) begin
            r_ph_q <= m_ph[i_ctl.wheel];
        end
        if (i_ctl.tk_wr) begin
            r_ph  <= w_ph_new;
            r_vsh <= r_vol_q[7:4];
            r_sq  <= (i_ctl.wheel < tov_pkg::SQUARE_LIMIT);
        end
    end

    always_comb begin
        if (r_sq) begin
            w_wave = r_ph[7] ? -8'sd1 : 8'sd0;
        end else begin
            w_wave = tov_pkg::sine(r_ph[15:8]);
        end
    end

    assign w_prod = w_wave * $signed({1'b0, r_vsh});

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.tk_acc) begin
            r_acc <= r_acc + 16'(w_prod);
        end
    end

    // output word register
    logic               r_out_valid;
    logic signed [15:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_sample <= $signed(r_acc);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

    assign o_sts.is_tick  = (i_cmd == tov_pkg::CMD_TICK);
    assign o_sts.rebuild  = w_key_chg || w_bar_ok;
    assign o_sts.held     = r_held[i_ctl.key[KW-1:0]];
    assign o_sts.out_free = !r_out_valid || !i_stall;

endmodule

// ===== bench/tov_sample_checker.sv =====
// Checker for the tonewheel organ voice engine: watches both channels,
// predicts each tick's sample and compares. Depends on tov_pkg.
`timescale 1ns / 1ps
module tov_sample_checker #(
    parameter int KEY_COUNT = 62,
    parameter int BAR_COUNT = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [1:0]         i_cmd,
    input  logic [5:0]         i_key,
    input  logic [3:0]         i_drawbar_number,
    input  logic [3:0]         i_position,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_sample,
    output int                 o_errors,
    output int                 o_pending
);
    logic [15:0] phase_q [tov_pkg::WHEEL_COUNT];
    logic [7:0]  vol_q [tov_pkg::WHEEL_COUNT];
    logic        held_q [64];
    logic [6:0]  gain_q [9];
    logic [15:0] sample_q [$];

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        o_errors++;
    endtask

    function automatic int unsigned fold(input int unsigned w);
        if (w < 13) return w + 12;
        if (w > 103) return w - 24;
        if (w > 91) return w - 12;
        return w;
    endfunction

    task automatic rebuild_volumes();
        int unsigned w;
        int unsigned s;
        for (int i = 0; i < tov_pkg::WHEEL_COUNT; i++) vol_q[i] = '0;
        for (int k = 1; k < KEY_COUNT; k++) begin
            if (!held_q[k]) continue;
            for (int d = 0; d < BAR_COUNT; d++) begin
                w = fold(k + tov_pkg::HARMONIC_ROM[d]);
                if (w >= tov_pkg::WHEEL_COUNT) continue;
                s = vol_q[w] + gain_q[d];
                vol_q[w] = (s > 255) ? tov_pkg::VOL_CLIP : s[7:0];
            end
        end
    endtask

    task automatic tick_sample();
        logic [15:0] acc;
        int          wave;
        logic signed [7:0] sv;
        acc = '0;
        for (int w = 1; w < tov_pkg::WHEEL_COUNT; w++) begin
            if (vol_q[w] == 0) continue;
            phase_q[w] = phase_q[w] + tov_pkg::RATE_ROM[w];
            if (w < 13) begin
                wave = phase_q[w][7] ? -1 : 0;
            end else begin
                // full sine from the half table: upper half negated
                sv = $signed(tov_pkg::SINE_HALF[phase_q[w][14:8]]);
                if (phase_q[w][15]) sv = -sv;
                wave = sv;
            end
            acc = acc + 16'(wave * int'(vol_q[w] >> 4));
        end
        sample_q.push_back(acc);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tov_pkg::WHEEL_COUNT; i++) begin
                phase_q[i] = '0;
                vol_q[i] = '0;
            end
            for (int i = 0; i < 64; i++) held_q[i] = 1'b0;
            for (int i = 0; i < 9; i++) gain_q[i] = '0;
            sample_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    report($sformatf("unexpected sample %0d", i_sample));
                end else begin
                    if (i_sample !== sample_q[0])
                        report($sformatf("sample %0d, want %0d", i_sample,
                                         $signed(sample_q[0])));
                    void'(sample_q.pop_front());
                end
            end
            if (i_valid && !i_stall_in) begin
                case (tov_pkg::t_cmd'(i_cmd))
                    tov_pkg::CMD_TICK: tick_sample();
                    tov_pkg::CMD_KEY_DOWN, tov_pkg::CMD_KEY_UP: begin
                        if (i_key != 0 && i_key < KEY_COUNT &&
                            held_q[i_key] != (i_cmd == tov_pkg::CMD_KEY_DOWN)) begin
                            held_q[i_key] = (i_cmd == tov_pkg::CMD_KEY_DOWN);
                            rebuild_volumes();
                        end
                    end
                    default: begin
                        if (i_drawbar_number != 0 && i_drawbar_number <= BAR_COUNT &&
                            i_position <= tov_pkg::POS_MAX) begin
                            gain_q[i_drawbar_number - 1] = tov_pkg::LEVEL_ROM[i_position];
                            rebuild_volumes();
                        end
                    end
                endcase
            end
        end
        o_pending = sample_q.size();
    end
endmodule

// ===== bench/tb_tonewheel_organ_voice_engine_core.sv =====
// Top of the organ voice engine bench: clock, reset, command stimulus,
// output back-pressure and verdict. Depends on tov_pkg and tov_sample_checker.
`timescale 1ns / 1ps
module tb_tonewheel_organ_voice_engine_core;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_cmd = '0;
    logic [5:0]         i_key = '0;
    logic [3:0]         i_drawbar_number = '0;
    logic [3:0]         i_position = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_sample;

    int  errors;
    int  pending;
    int  cycles = 0;
    bit  quiet = 1'b0;     // no idling on either side
    bit  hold_off = 1'b0;  // long receiver hold-off requested

    tonewheel_organ_voice_engine_core dut (.*);

    tov_sample_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_cmd, .i_key,
        .i_drawbar_number, .i_position, .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_sample(o_sample),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall, or a long counted hold-off
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                for (n = 0; n < 3000; n++) @(negedge i_clk);
                hold_off = 1'b0;
            end
            i_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    // send one word; random idle gap before it, held until taken
    task automatic send_word(input logic [1:0] c, input logic [5:0] k,
                             input logic [3:0] b, input logic [3:0] p);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c;
        i_key <= k;
        i_drawbar_number <= b;
        i_position <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            send_word(tov_pkg::CMD_TICK, 6'($urandom), 4'($urandom), 4'($urandom));
        else if (r < 60)
            send_word(tov_pkg::CMD_KEY_DOWN, 6'($urandom_range(61, 1)), 4'($urandom),
                      4'($urandom));
        else if (r < 78)
            send_word(tov_pkg::CMD_KEY_UP, 6'($urandom_range(61, 1)), 4'($urandom),
                      4'($urandom));
        else if (r < 92)
            send_word(tov_pkg::CMD_DRAWBAR, 6'($urandom), 4'($urandom_range(9, 1)),
                      4'($urandom_range(8)));
        else
            // noise: random command and fields, in range or out of range
            send_word(2'($urandom), 6'($urandom), 4'($urandom), 4'($urandom));
    endtask

    initial begin
        int wait_cycles;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: silent tick, drawbar extremes, key extremes, overflow clip
        send_word(tov_pkg::CMD_TICK, 6'd0, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'd1, 4'd8);
        send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'd9, 4'd8);
        send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'd0, 4'd5);   // bar out of range
        send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'd10, 4'd5);  // bar out of range
        send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'd15, 4'd3);
        send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'd3, 4'd15);  // position out of range
        send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'd3, 4'd9);
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd1, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd61, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd0, 4'd0, 4'd0);   // key out of range
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd62, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd63, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd61, 4'd0, 4'd0);  // repeat down
        send_word(tov_pkg::CMD_TICK, 6'd63, 4'd15, 4'd15);
        for (int b = 2; b <= 8; b++) send_word(tov_pkg::CMD_DRAWBAR, 6'd0, 4'(b), 4'd8);
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd13, 4'd0, 4'd0);  // many keys share wheels
        send_word(tov_pkg::CMD_KEY_DOWN, 6'd25, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_TICK, 6'd0, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_KEY_UP, 6'd40, 4'd0, 4'd0);    // release of unheld key
        send_word(tov_pkg::CMD_KEY_UP, 6'd1, 4'd0, 4'd0);
        send_word(tov_pkg::CMD_TICK, 6'd0, 4'd0, 4'd0);

        // random, with a quiet stretch and a long output hold-off
        for (int i = 0; i < 450; i++) begin
            quiet = (i >= 100 && i < 180);
            if (i == 250) hold_off = 1'b1;
            send_random();
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        for (wait_cycles = 0; wait_cycles < 1500; wait_cycles++) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
